FILE: design/cra_pkg.sv
// Shared types and constants of the contiguous ring allocator.
`default_nettype none

package cra_pkg;

  localparam int IdxWidth = 22;
  localparam longint unsigned IdxMax = (64'd1 << IdxWidth) - 64'd1;

  // Capacity after reset, before any configuration write
  localparam logic [IdxWidth-1:0] ResetCap = 22'd2097152;
  localparam logic [IdxWidth-1:0] MinCap   = 22'd2;

  typedef enum logic {
    MODE_ACQUIRE = 1'b0,
    MODE_CONSUME = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t               mode;
    logic [IdxWidth-1:0] alloc_size;
  } item_t;

  typedef struct packed {
    logic                granted;
    logic [IdxWidth-1:0] alloc_offset;
    logic [IdxWidth-1:0] first_offset;
    logic [IdxWidth-1:0] first_length;
    logic [IdxWidth-1:0] second_length;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACQ_TRY,
    ST_ACQ_RETRY,
    ST_CONSUME
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the input transaction
    logic rebuild;   // recompute the free window
    logic acq_done;  // commit acquire, write result
    logic con_done;  // commit consume, write result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fits;      // request fits the current window
    logic out_free;  // result register can take a new result
  } status_t;

endpackage

`default_nettype wire

FILE: design/contiguous_ring_allocator_core.sv
// Top level of the contiguous ring allocator: controller plus datapath.
//
// Input channel in_valid/in_stall/in_data carries one request: an acquire
// (mode 0) of alloc_size bytes, or a consume (mode 1) of all committed data.
// Output channel out_valid/out_stall/out_data carries one result per request.
// cfg_write_en/cfg_write_data set the ring capacity; write only while idle.
// An acquire that fits the cached window writes its result from the try
// step; a miss adds a retry step after the window rebuild. A consume writes
// its result from the consume step. One request is in flight at a time, so
// the block takes no new request until the last one's result is written.
// The result register lets the next request be accepted while a result
// waits; a stalled receiver holds the result and the controller waits in
// its final step until the result register frees up.
// Reset clears all indices and the window and sets capacity to ResetCap,
// clamped to the capacity limit; no clearing pass is needed.
`default_nettype none

module contiguous_ring_allocator_core
  import cra_pkg::*;
#(
  parameter longint unsigned MAX_CAPACITY = 2097152
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  item_t               in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output result_t             out_data,
  input  wire                 cfg_write_en,
  input  wire  [IdxWidth-1:0] cfg_write_data
);

  localparam logic [IdxWidth-1:0] CapLimit =
    (MAX_CAPACITY > IdxMax) ? IdxWidth'(IdxMax) : MAX_CAPACITY[IdxWidth-1:0];

  cmd_t    cmd;
  status_t status;

  cra_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  cra_datapath #(
    .CAP_LIMIT (CapLimit)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .in_data        (in_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_stall      (out_stall),
    .status         (status),
    .out_valid      (out_valid),
    .out_data       (out_data)
  );

  // One transaction in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a request is in flight");

  // A new result only comes out of a request in progress
  a_result_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result produced without a request");

  // Granted acquire results carry no segments
  a_grant_no_segments: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.granted) |->
      (out_data.first_length == '0 && out_data.second_length == '0 &&
       out_data.first_offset == '0))
    else $error("granted result carries readable segments");

  // A zero offset is the only offset of a result that was not granted
  a_offset_needs_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.granted || out_data.alloc_offset == '0))
    else $error("offset reported without a grant");

endmodule

`default_nettype wire

FILE: design/cra_controller.sv
// Sequencing state machine of the contiguous ring allocator.
`default_nettype none

module cra_controller
  import cra_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     in_valid,
  input  mode_t   in_mode,
  input  status_t status,
  output logic    in_stall,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_mode == MODE_CONSUME) ? ST_CONSUME : ST_ACQ_TRY;
        end
      end
      ST_ACQ_TRY: begin
        // Miss on the cached window: rebuild, then try once more
        if (!status.fits) begin
          state_next = ST_ACQ_RETRY;
        end else if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_ACQ_RETRY, ST_CONSUME: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_ACQ_TRY: begin
        cmd.rebuild  = !status.fits;
        cmd.acq_done = status.fits && status.out_free;
      end
      ST_ACQ_RETRY: begin
        cmd.acq_done = status.out_free;
      end
      ST_CONSUME: begin
        cmd.con_done = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/cra_datapath.sv
// Index registers, window arithmetic and result register of the ring allocator.
`default_nettype none

module cra_datapath
  import cra_pkg::*;
#(
  parameter logic [IdxWidth-1:0] CAP_LIMIT = 22'd2097152
) (
  input  wire                 clk,
  input  wire                 rst,
  input  cmd_t                cmd,
  input  item_t               in_data,
  input  wire                 cfg_write_en,
  input  wire  [IdxWidth-1:0] cfg_write_data,
  input  wire                 out_stall,
  output status_t             status,
  output logic                out_valid,
  output result_t             out_data
);

  function automatic logic [IdxWidth-1:0] clamp_cap(input logic [IdxWidth-1:0] v);
    logic [IdxWidth-1:0] c;
    c = v;
    if (c > CAP_LIMIT) c = CAP_LIMIT;
    if (c < MinCap) c = MinCap;
    return c;
  endfunction

  logic [IdxWidth-1:0] capacity;
  logic [IdxWidth-1:0] write_index;
  logic [IdxWidth-1:0] read_index;
  logic [IdxWidth-1:0] wrap_end;
  logic [IdxWidth-1:0] window_pos;
  logic [IdxWidth-1:0] window_end;
  item_t               item;

  // Free window room; an inverted window is empty
  logic [IdxWidth-1:0] room;
  logic                fits;

  always_comb begin
    room = (window_end > window_pos) ? (window_end - window_pos) : '0;
    fits = (item.alloc_size <= room);
  end

  // Rebuild terms, signed with two guard bits
  logic signed [IdxWidth+1:0] tail;
  logic signed [IdxWidth+1:0] head;
  logic [IdxWidth-1:0]        read_m1;

  always_comb begin
    tail    = $signed({2'b00, capacity}) - $signed({2'b00, write_index});
    head    = $signed({2'b00, read_index}) - $signed((IdxWidth+2)'(1));
    read_m1 = read_index - IdxWidth'(1);
  end

  logic [IdxWidth-1:0] pos_adv;
  assign pos_adv = window_pos + item.alloc_size;

  // Acquire result
  result_t acq_result;

  always_comb begin
    acq_result              = '0;
    acq_result.granted      = fits;
    acq_result.alloc_offset = fits ? window_pos : '0;
  end

  // Consume segments
  result_t con_result;

  always_comb begin
    con_result = '0;
    if (read_index <= write_index) begin
      con_result.first_offset = read_index;
      con_result.first_length = write_index - read_index;
    end else if (read_index < wrap_end) begin
      con_result.first_offset  = read_index;
      con_result.first_length  = wrap_end - read_index;
      con_result.second_length = write_index;
    end else begin
      con_result.first_length = write_index;
    end
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    status.fits     = fits;
    status.out_free = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= clamp_cap(ResetCap);
      write_index <= '0;
      read_index  <= '0;
      wrap_end    <= '0;
      window_pos  <= '0;
      window_end  <= '0;
    end else begin
      if (cfg_write_en) begin
        capacity <= clamp_cap(cfg_write_data);
      end
      if (cmd.rebuild) begin
        if (write_index < read_index) begin
          window_pos <= write_index;
          window_end <= read_m1;
        end else if (tail >= head) begin
          window_pos <= write_index;
          window_end <= capacity;
        end else begin
          wrap_end   <= write_index;
          window_pos <= '0;
          window_end <= read_m1;
        end
      end
      if (cmd.acq_done && fits) begin
        window_pos  <= pos_adv;
        write_index <= pos_adv;
      end
      if (cmd.con_done) begin
        read_index <= write_index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.acq_done || cmd.con_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acq_done) begin
      out_data <= acq_result;
    end else if (cmd.con_done) begin
      out_data <= con_result;
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the contiguous ring allocator core.
module tb_top;
  import cra_pkg::*;

  localparam longint unsigned MaxCap = 2097152;
  localparam int WatchdogLimit = 4000;
  localparam int LongHoldCycles = 400;
  localparam int NumPhases = 7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  item_t in_data = '0;
  logic out_stall = 1'b0;
  logic cfg_write_en = 1'b0;
  logic [IdxWidth-1:0] cfg_write_data = '0;
  logic in_stall;
  logic out_valid;
  result_t out_data;

  // requests waiting to be driven, results waiting to be seen
  item_t request_q[$];
  result_t pending_results[$];

  // allocator state as the checker sees it
  logic [IdxWidth-1:0] ring_cap = ResetCap;
  logic [IdxWidth-1:0] wr_idx = '0;
  logic [IdxWidth-1:0] rd_idx = '0;
  logic [IdxWidth-1:0] wrap_idx = '0;
  logic [IdxWidth-1:0] win_pos = '0;
  logic [IdxWidth-1:0] win_end = '0;

  int tx_idle_pct = 7;
  int rx_idle_pct = 67;
  logic long_hold_req = 1'b0;
  logic long_hold_taken = 1'b0;
  int long_hold_left = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  contiguous_ring_allocator_core #(
    .MAX_CAPACITY(MaxCap)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [IdxWidth-1:0] cap_eff();
    if (longint'(ring_cap) > longint'(MaxCap)) return IdxWidth'(MaxCap);
    if (ring_cap < MinCap) return MinCap;
    return ring_cap;
  endfunction

  // An inverted window counts as empty
  function automatic logic [IdxWidth-1:0] win_room();
    return (win_end > win_pos) ? win_end - win_pos : '0;
  endfunction

  function automatic result_t ring_step(item_t req);
    result_t res;
    logic fits;
    longint tail;
    longint head;
    res = '0;
    if (req.mode == MODE_ACQUIRE) begin
      fits = req.alloc_size <= win_room();
      if (!fits) begin
        if (wr_idx < rd_idx) begin
          win_pos = wr_idx;
          win_end = rd_idx - 1'b1;
        end else begin
          tail = longint'(cap_eff()) - longint'(wr_idx);
          head = longint'(rd_idx) - 1;
          if (tail >= head) begin
            win_pos = wr_idx;
            win_end = cap_eff();
          end else begin
            // take the head of the ring, remember where the data wraps
            wrap_idx = wr_idx;
            win_pos = '0;
            win_end = head[IdxWidth-1:0];
          end
        end
        fits = req.alloc_size <= win_room();
      end
      if (fits) begin
        res.granted = 1'b1;
        res.alloc_offset = win_pos;
        win_pos = win_pos + req.alloc_size;
        wr_idx = win_pos;
      end
    end else begin
      if (rd_idx <= wr_idx) begin
        res.first_offset = rd_idx;
        res.first_length = wr_idx - rd_idx;
      end else if (rd_idx < wrap_idx) begin
        res.first_offset = rd_idx;
        res.first_length = wrap_idx - rd_idx;
        res.second_length = wr_idx;
      end else begin
        res.first_length = wr_idx;
      end
      rd_idx = wr_idx;
    end
    return res;
  endfunction

  function automatic item_t random_request();
    item_t req;
    logic [IdxWidth-1:0] c;
    int pick;
    c = cap_eff();
    pick = $urandom_range(99);
    req.alloc_size = IdxWidth'($urandom);
    if (pick < 25) begin
      req.mode = MODE_CONSUME;
    end else begin
      req.mode = MODE_ACQUIRE;
      if (pick < 30) req.alloc_size = '0;
      else if (pick < 72) req.alloc_size = IdxWidth'($urandom_range(0, c / 4));
      else if (pick < 90) req.alloc_size = IdxWidth'($urandom_range(0, c));
    end
    return req;
  endfunction

  function automatic logic [IdxWidth-1:0] phase_cap(int p);
    case (p)
      0: return 22'h3FFFFF;
      1: return 22'd64;
      2: return 22'd1;
      3: return 22'd1000;
      4: return 22'd2097152;
      5: return 22'd3;
      default: return 22'd255;
    endcase
  endfunction

  function automatic int phase_items(int p);
    case (p)
      2, 5: return 150;
      6: return 430;
      default: return 300;
    endcase
  endfunction

  task automatic queue_request(mode_t m, int unsigned sz);
    item_t req;
    req.mode = m;
    req.alloc_size = IdxWidth'(sz);
    request_q = {request_q, req};
  endtask

  // hold until the block has nothing in flight
  task automatic drain_wait();
    while (request_q.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [IdxWidth-1:0] value);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    ring_cap = value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) pending_results = {pending_results, ring_step(in_data)};
      if (!in_valid || !in_stall) begin
        if (request_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_data <= request_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off on request
  always @(posedge clk) begin
    if (long_hold_req && !long_hold_taken) begin
      long_hold_taken <= 1'b1;
      long_hold_left <= LongHoldCycles;
      out_stall <= 1'b1;
    end else if (long_hold_left > 0) begin
      long_hold_left <= long_hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < rx_idle_pct;
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected result %h/%h/%h/%h/%h", out_data.granted,
                   out_data.alloc_offset, out_data.first_offset,
                   out_data.first_length, out_data.second_length);
      end else begin
        want = pending_results.pop_front();
        if (out_data.granted !== want.granted
            || out_data.alloc_offset !== want.alloc_offset
            || out_data.first_offset !== want.first_offset
            || out_data.first_length !== want.first_length
            || out_data.second_length !== want.second_length) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected %h/%h/%h/%h/%h actual %h/%h/%h/%h/%h",
                     want.granted, want.alloc_offset, want.first_offset,
                     want.first_length, want.second_length, out_data.granted,
                     out_data.alloc_offset, out_data.first_offset,
                     out_data.first_length, out_data.second_length);
        end
      end
    end
  end

  // watchdog on stalled progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim
    int n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // full-size ring: zero size, oversized miss, small grant
    queue_request(MODE_ACQUIRE, 0);
    queue_request(MODE_ACQUIRE, 22'h3FFFFF);
    queue_request(MODE_ACQUIRE, 3);
    drain_wait();

    // capacity below the minimum, write index past the end: inverted window
    set_capacity(22'd0);
    queue_request(MODE_ACQUIRE, 22'h3FFFFF);
    queue_request(MODE_ACQUIRE, 0);
    queue_request(MODE_ACQUIRE, 1);
    queue_request(MODE_CONSUME, 22'h3FFFFF);
    queue_request(MODE_ACQUIRE, 1);
    queue_request(MODE_ACQUIRE, 1);
    queue_request(MODE_ACQUIRE, 1);
    queue_request(MODE_CONSUME, 0);
    drain_wait();

    // small ring: tail, wrap to head, two-segment consume, oversized request
    set_capacity(22'd16);
    queue_request(MODE_ACQUIRE, 10);
    queue_request(MODE_CONSUME, 0);
    queue_request(MODE_ACQUIRE, 3);
    queue_request(MODE_ACQUIRE, 5);
    queue_request(MODE_CONSUME, 0);
    queue_request(MODE_ACQUIRE, 20);
    queue_request(MODE_ACQUIRE, 11);
    queue_request(MODE_CONSUME, 0);

    for (int p = 0; p < NumPhases; p++) begin
      drain_wait();
      set_capacity(phase_cap(p));
      tx_idle_pct <= (p < 2) ? 7 : (p < 4) ? 67 : 0;
      rx_idle_pct <= (p < 2) ? 67 : (p < 4) ? 7 : 0;
      if (p == 1) long_hold_req <= 1'b1;
      n = phase_items(p);
      for (int i = 0; i < n / 2; i++) request_q = {request_q, random_request()};
      // let the block go idle mid-phase
      drain_wait();
      for (int i = n / 2; i < n; i++) request_q = {request_q, random_request()};
    end

    drain_wait();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
